FILE: hw/rtl/co2fpa_pkg.sv
// Package for the CO2 sensor frame parser and averager.
// Holds frame constants, status codes, register map and state type.
// No dependencies; compiled first.
`default_nettype none

package co2fpa_pkg;

   // default sizes of the reading accumulators
   localparam int COUNT_WIDTH_DEF = 16;
   localparam int SUM_WIDTH_DEF   = 32;

   // frame format
   localparam logic [7:0]  START_BYTE     = 8'hFF;
   localparam logic [7:0]  CMD_BYTE       = 8'h86;
   localparam logic [15:0] NOT_READY_MARK = 16'd15000;
   localparam logic [3:0]  FRAME_LAST     = 4'd8;

   // register map
   localparam int          CSR_ADDR_W    = 4;
   localparam logic [1:0]  REG_PPM_MIN   = 2'd0;
   localparam logic [1:0]  REG_PPM_MAX   = 2'd1;
   localparam logic [1:0]  REG_GOOD_STAT = 2'd2;

   localparam logic [15:0] PPM_MIN_RESET   = 16'd100;
   localparam logic [15:0] PPM_MAX_RESET   = 16'd6000;
   localparam logic [7:0]  GOOD_STAT_RESET = 8'd64;

   // result status codes
   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_UNRELIABLE = 3'd1;
   localparam logic [2:0] STATUS_FRAME_ERR  = 3'd2;
   localparam logic [2:0] STATUS_NOT_READY  = 3'd3;
   localparam logic [2:0] STATUS_RANGE      = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/co2fpa_if.sv
// Handshake channels of the CO2 frame parser: received byte in, frame result out.
// Valid/ready, a beat moves when both are high. Depends on nothing.
`default_nettype none

interface co2fpa_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       avg_clear;

   modport source (output valid, output rx_byte, output avg_clear, input ready);
   modport sink   (input valid, input rx_byte, input avg_clear, output ready);
endinterface

interface co2fpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] ppm;
   logic [15:0] average;
   logic        average_valid;

   modport source (output valid, output status, output ppm, output average,
                   output average_valid, input ready);
   modport sink   (input valid, input status, input ppm, input average,
                   input average_valid, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/co2_sensor_frame_parser_averager_unit.sv
// CO2 sensor frame parser and running averager, top level.
// Depends on co2fpa_pkg and the channel interfaces in co2fpa_if.sv.
//
// req_bus carries one received UART byte per beat plus avg_clear. The block
// hunts for 0xFF, collects the 8 bytes after it and, on the ninth byte,
// checks checksum, command, not-ready marker, ppm range and status byte.
// rsp_bus then gives one beat: status, ppm, running average and its valid.
// Bytes that do not end a frame give nothing.
// The ninth byte is handled in steps: evaluate, accumulate, SUM_WIDTH steps
// of a shared restoring subtract/compare unit for sum / count, and load the
// output register.
// With no good reading held the divide is skipped.
// req_bus.ready is low from the accumulate step until the output register is loaded.
// The result sits in an output register; the next frame's bytes are taken
// while it waits. If rsp_bus stalls until the next frame is finished, that
// frame waits in its last step until the register frees.
// avg_clear on the ninth byte clears sum and count after the average is
// taken. csr_* is an APB-style write/read port for ppm_min, ppm_max and
// good_status_byte. Synchronous reset returns to hunting with empty sum and
// count and the register reset values; no result is pending after reset.
`default_nettype none

module co2_sensor_frame_parser_averager_unit #(
   parameter int COUNT_WIDTH = co2fpa_pkg::COUNT_WIDTH_DEF,
   parameter int SUM_WIDTH   = co2fpa_pkg::SUM_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   co2fpa_req_if.sink                             req_bus,
   co2fpa_rsp_if.source                           rsp_bus,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [co2fpa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic      [31:0]                       csr_prdata,
   output logic                                   csr_pready
);
   import co2fpa_pkg::*;

   localparam int ITER_W = $clog2(SUM_WIDTH);

   // configuration
   logic [15:0] ppm_min_ff, ppm_max_ff;
   logic [7:0]  good_stat_ff;
   logic        csr_write;

   // frame collection
   state_type        state_ff, state_in;
   logic [3:0]       pos_ff, pos_in;
   logic [7:0]       chk_ff, chk_in;
   logic [7:0]       frame_ff [1:7];
   logic             frame_we;

   // evaluated frame
   logic [2:0]       status_ff, status_in;
   logic [15:0]      ppm_ff, ppm_in;
   logic             clear_ff, clear_in;

   // accumulators and divider
   logic [SUM_WIDTH-1:0]   sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [SUM_WIDTH-1:0]   quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [ITER_W-1:0]      iter_ff, iter_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_ppm_ff, rsp_ppm_in;
   logic [15:0] rsp_avg_ff, rsp_avg_in;
   logic        rsp_avgv_ff, rsp_avgv_in;

   // combinational helpers
   logic                 req_fire;
   logic                 hunting;
   logic [15:0]          frame_ppm, frame_marker;
   logic                 frame_bad;
   logic [2:0]           frame_status;
   logic [SUM_WIDTH:0]   sum_ext;
   logic [SUM_WIDTH-1:0] sum_sat;
   logic [COUNT_WIDTH:0] trial;
   logic                 trial_ge;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ppm_min_ff   <= PPM_MIN_RESET;
         ppm_max_ff   <= PPM_MAX_RESET;
         good_stat_ff <= GOOD_STAT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[CSR_ADDR_W-1:2])
            REG_PPM_MIN:   ppm_min_ff   <= csr_pwdata[15:0];
            REG_PPM_MAX:   ppm_max_ff   <= csr_pwdata[15:0];
            REG_GOOD_STAT: good_stat_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[CSR_ADDR_W-1:2])
         REG_PPM_MIN:   csr_prdata = {16'd0, ppm_min_ff};
         REG_PPM_MAX:   csr_prdata = {16'd0, ppm_max_ff};
         REG_GOOD_STAT: csr_prdata = {24'd0, good_stat_ff};
         default:       csr_prdata = 32'd0;
      endcase
   end

   // ---------------- frame checks ----------------
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign hunting       = (pos_ff == 4'd0) || (pos_ff > FRAME_LAST);

   assign frame_ppm    = {frame_ff[2], frame_ff[3]};
   assign frame_marker = {frame_ff[6], frame_ff[7]};
   assign frame_bad    = (8'(8'd0 - chk_ff) != req_bus.rx_byte) || (frame_ff[1] != CMD_BYTE);

   always_comb begin
      if (frame_bad)
         frame_status = STATUS_FRAME_ERR;
      else if (frame_marker == NOT_READY_MARK)
         frame_status = STATUS_NOT_READY;
      else if (frame_ppm < ppm_min_ff || frame_ppm > ppm_max_ff)
         frame_status = STATUS_RANGE;
      else if (frame_ff[5] != good_stat_ff)
         frame_status = STATUS_UNRELIABLE;
      else
         frame_status = STATUS_OK;
   end

   // saturating add of the reading
   assign sum_ext = {1'b0, sum_ff} + (SUM_WIDTH+1)'(ppm_ff);
   assign sum_sat = sum_ext[SUM_WIDTH] ? '1 : sum_ext[SUM_WIDTH-1:0];

   // shared restoring-division step: shift in one dividend bit, trial subtract
   assign trial    = {rem_ff, quo_ff[SUM_WIDTH-1]};
   assign trial_ge = (trial >= {1'b0, count_ff});

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      chk_in        = chk_ff;
      frame_we      = 1'b0;
      status_in     = status_ff;
      ppm_in        = ppm_ff;
      clear_in      = clear_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      iter_in       = iter_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_ppm_in    = rsp_ppm_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_avgv_in   = rsp_avgv_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (hunting) begin
                  pos_in = 4'd0;
                  if (req_bus.rx_byte == START_BYTE) begin
                     chk_in = 8'd0;
                     pos_in = 4'd1;
                  end
               end else if (pos_ff < FRAME_LAST) begin
                  frame_we = 1'b1;
                  chk_in   = chk_ff + req_bus.rx_byte;
                  pos_in   = pos_ff + 4'd1;
               end else begin
                  pos_in    = 4'd0;
                  status_in = frame_status;
                  ppm_in    = frame_bad ? 16'd0 : frame_ppm;
                  clear_in  = req_bus.avg_clear;
                  state_in  = ST_ACCUM;
               end
            end
         end
         ST_ACCUM: begin
            if (status_ff == STATUS_OK && !(&count_ff)) begin
               count_in = count_ff + COUNT_WIDTH'(1);
               sum_in   = sum_sat;
            end
            quo_in   = sum_in;
            rem_in   = '0;
            iter_in  = '0;
            state_in = (count_in == '0) ? ST_DONE : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in  = trial_ge ? COUNT_WIDTH'(trial - {1'b0, count_ff})
                               : trial[COUNT_WIDTH-1:0];
            quo_in  = {quo_ff[SUM_WIDTH-2:0], trial_ge};
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(SUM_WIDTH - 1))
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_ppm_in    = ppm_ff;
               rsp_avgv_in   = (count_ff != '0);
               rsp_avg_in    = (count_ff != '0) ? quo_ff[15:0] : 16'd0;
               if (clear_ff) begin
                  sum_in   = '0;
                  count_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= 4'd0;
         chk_ff       <= 8'd0;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         chk_ff       <= chk_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      ppm_ff        <= ppm_in;
      clear_ff      <= clear_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      iter_ff       <= iter_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ppm_ff    <= rsp_ppm_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_avgv_ff   <= rsp_avgv_in;
   end

   // frame byte store, positions 1..7
   always_ff @(posedge clock) begin
      if (frame_we)
         frame_ff[pos_ff[2:0]] <= req_bus.rx_byte;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.ppm           = rsp_ppm_ff;
   assign rsp_bus.average       = rsp_avg_ff;
   assign rsp_bus.average_valid = rsp_avgv_ff;

   // ---------------- assertions ----------------
   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> sum_ff == '0)
      else $error("sum nonzero with empty count");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= FRAME_LAST)
      else $error("byte position beyond frame");

   a_err_ppm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_FRAME_ERR |-> rsp_ppm_ff == 16'd0)
      else $error("frame error beat carries ppm");

   a_ok_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_OK |-> rsp_avgv_ff)
      else $error("good reading without valid average");

endmodule

`default_nettype wire

FILE: dv/co2_sensor_frame_parser_averager_unit_tb.sv
// Self-checking bench for co2_sensor_frame_parser_averager_unit: sensor reply frames in,
// status/ppm/average beats out, checked against a cycle-free frame predictor.
// Depends on co2fpa_pkg and the channel interfaces in the RTL.

module co2_sensor_frame_parser_averager_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import co2fpa_pkg::*;

   localparam int SUM_W        = SUM_WIDTH_DEF;
   localparam int COUNT_W      = COUNT_WIDTH_DEF;
   localparam int SETTLE_CYC   = SUM_W + 25;
   localparam int HOLD_CYC     = 400;
   localparam int PHASE_BYTES  = 95;
   localparam int NUM_PHASES   = 6;
   localparam int CYCLE_LIMIT  = 300000;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] ppm;
      logic [15:0] average;
      logic        average_valid;
   } frame_result_type;

   typedef enum int {
      FK_GOOD,
      FK_UNRELIABLE,
      FK_BAD_SUM,
      FK_BAD_CMD,
      FK_NOT_READY,
      FK_RANGE_LOW,
      FK_RANGE_HIGH
   } frame_kind_type;

   // Frame parser/averager predictor plus the queue of results it still owes.
   class frame_scoreboard;
      logic [3:0]         byte_pos;
      logic [7:0]         frame_buf [8];
      logic [7:0]         sum_acc;
      logic [SUM_W-1:0]   reading_sum;
      logic [COUNT_W-1:0] reading_count;
      logic [15:0]        ppm_lo_lim;
      logic [15:0]        ppm_hi_lim;
      logic [7:0]         good_stat;
      frame_result_type   expected_frames [$];
      int                 error_count;
      int                 status_tally [5];

      function new();
         byte_pos      = '0;
         sum_acc       = '0;
         reading_sum   = '0;
         reading_count = '0;
         ppm_lo_lim    = PPM_MIN_RESET;
         ppm_hi_lim    = PPM_MAX_RESET;
         good_stat     = GOOD_STAT_RESET;
         error_count   = 0;
         foreach (frame_buf[i]) frame_buf[i] = '0;
         foreach (status_tally[i]) status_tally[i] = 0;
      endfunction

      function void apply_reg_write(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_PPM_MIN:   ppm_lo_lim = value[15:0];
            REG_PPM_MAX:   ppm_hi_lim = value[15:0];
            REG_GOOD_STAT: good_stat  = value[7:0];
            default: ;
         endcase
      endfunction

      function void note_rx_byte(logic [7:0] b, logic clr);
         frame_result_type res;
         logic [15:0]      marker;
         logic [7:0]       want_sum;
         logic [SUM_W:0]   wide_sum;
         if (byte_pos == 0 || byte_pos > FRAME_LAST) begin
            byte_pos = '0;
            if (b == START_BYTE) begin
               frame_buf[0] = b;
               sum_acc      = '0;
               byte_pos     = 4'd1;
            end
            return;
         end
         if (byte_pos < FRAME_LAST) begin
            frame_buf[byte_pos[2:0]] = b;
            sum_acc  = sum_acc + b;
            byte_pos = byte_pos + 4'd1;
            return;
         end
         // last byte of the reply: evaluate in check order
         byte_pos = '0;
         res.ppm  = {frame_buf[2], frame_buf[3]};
         marker   = {frame_buf[6], frame_buf[7]};
         want_sum = 8'd0 - sum_acc;
         if (want_sum != b || frame_buf[1] != CMD_BYTE) begin
            res.status = STATUS_FRAME_ERR;
            res.ppm    = '0;
         end else if (marker == NOT_READY_MARK) begin
            res.status = STATUS_NOT_READY;
         end else if (res.ppm < ppm_lo_lim || res.ppm > ppm_hi_lim) begin
            res.status = STATUS_RANGE;
         end else if (frame_buf[5] != good_stat) begin
            res.status = STATUS_UNRELIABLE;
         end else begin
            res.status = STATUS_OK;
         end
         if (res.status == STATUS_OK && reading_count != '1) begin
            reading_count = reading_count + 1'b1;
            wide_sum      = {1'b0, reading_sum} + (SUM_W+1)'(res.ppm);
            reading_sum   = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
         end
         res.average       = '0;
         res.average_valid = 1'b0;
         if (reading_count != 0) begin
            wide_sum          = (SUM_W+1)'(reading_sum / reading_count);
            res.average       = wide_sum[15:0];
            res.average_valid = 1'b1;
         end
         if (clr) begin
            reading_sum   = '0;
            reading_count = '0;
         end
         status_tally[res.status]++;
         expected_frames.push_back(res);
      endfunction

      function void check_frame_result(frame_result_type got);
         frame_result_type want;
         if (expected_frames.size() == 0) begin
            $error("unexpected result beat: status %0d ppm %0d", got.status, got.ppm);
            error_count++;
            return;
         end
         want = expected_frames.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
         end
         if (got.ppm !== want.ppm) begin
            $error("ppm: expected %0d, got %0d", want.ppm, got.ppm);
            error_count++;
         end
         if (got.average !== want.average) begin
            $error("average: expected %0d, got %0d", want.average, got.average);
            error_count++;
         end
         if (got.average_valid !== want.average_valid) begin
            $error("average_valid: expected %0d, got %0d", want.average_valid,
                   got.average_valid);
            error_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   co2fpa_req_if req_bus ();
   co2fpa_rsp_if rsp_bus ();

   co2_sensor_frame_parser_averager_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   frame_scoreboard sb = new();
   bit tx_quiet;
   bit rx_quiet;
   bit hold_request;
   int cycle_count;
   int frame_bytes;
   int stray_bytes;
   int reg_writes;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   function automatic int draw_wait(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 16);
   endfunction

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int               stall;
      frame_result_type got;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYC) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            stall = draw_wait(rx_quiet);
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.status        = rsp_bus.status;
         got.ppm           = rsp_bus.ppm;
         got.average       = rsp_bus.average;
         got.average_valid = rsp_bus.average_valid;
         sb.check_frame_result(got);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic clr);
      int gap;
      gap = draw_wait(tx_quiet);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.rx_byte   <= b;
      req_bus.avg_clear <= clr;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_rx_byte(b, clr);
   endtask

   task automatic send_frame(input frame_kind_type kind, input logic [15:0] ppm,
                             input bit clr);
      logic [7:0]  fb [9];
      logic [7:0]  sum;
      logic [7:0]  flip;
      logic [15:0] marker;
      flip   = 8'($urandom_range(1, 255));
      marker = (kind == FK_NOT_READY) ? NOT_READY_MARK : 16'($urandom_range(0, 65535));
      fb[0]  = START_BYTE;
      fb[1]  = (kind == FK_BAD_CMD) ? CMD_BYTE ^ flip : CMD_BYTE;
      fb[2]  = ppm[15:8];
      fb[3]  = ppm[7:0];
      fb[4]  = 8'($urandom_range(0, 255));
      fb[5]  = (kind == FK_UNRELIABLE) ? sb.good_stat ^ flip : sb.good_stat;
      fb[6]  = marker[15:8];
      fb[7]  = marker[7:0];
      sum    = '0;
      for (int i = 1; i < 8; i++) sum = sum + fb[i];
      fb[8]  = 8'd0 - sum;
      if (kind == FK_BAD_SUM) fb[8] = fb[8] ^ flip;
      // avg_clear only matters on the checksum byte; toggle it elsewhere anyway
      for (int i = 0; i < 9; i++)
         send_byte(fb[i], (i == 8) ? clr : ($urandom_range(0, 3) == 0));
      frame_bytes += 9;
   endtask

   function automatic logic [15:0] pick_ppm(input frame_kind_type kind);
      logic [15:0] lo;
      logic [15:0] hi;
      int          sel;
      lo  = sb.ppm_lo_lim;
      hi  = sb.ppm_hi_lim;
      sel = $urandom_range(0, 3);
      case (kind)
         FK_RANGE_LOW:
            if (lo > 0) return (sel == 0) ? lo - 16'd1 : 16'($urandom_range(0, lo - 1));
         FK_RANGE_HIGH:
            if (hi < 16'hFFFF)
               return (sel == 0) ? hi + 16'd1 : 16'($urandom_range(hi + 1, 16'hFFFF));
         default:
            if (lo <= hi) begin
               case (sel)
                  0: return lo;
                  1: return hi;
                  default: return 16'($urandom_range(lo, hi));
               endcase
            end
      endcase
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.apply_reg_write(idx, value);
      reg_writes++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic set_phase_regs(input int phase);
      logic [15:0] lo;
      logic [15:0] hi;
      logic [7:0]  gs;
      logic [31:0] junk;
      junk = $urandom;
      gs   = 8'($urandom_range(0, 255));
      case (phase)
         1: begin lo = 16'h0000; hi = 16'hFFFF; gs = 8'h00; end
         2: begin lo = 16'hFFFF; hi = 16'h0000; gs = 8'hFF; end
         3: begin lo = 16'($urandom_range(200, 5000)); hi = lo; end
         4: begin lo = PPM_MIN_RESET; hi = PPM_MAX_RESET; gs = GOOD_STAT_RESET; end
         default: begin
            lo = 16'($urandom_range(0, 30000));
            hi = 16'($urandom_range(lo, 65535));
         end
      endcase
      // upper bits of pwdata carry junk the registers must drop
      csr_write(REG_PPM_MIN, {junk[31:16], lo});
      csr_write(REG_PPM_MAX, {junk[15:0], hi});
      csr_write(REG_GOOD_STAT, {junk[23:0], gs});
   endtask

   task automatic random_step();
      int             r;
      int             n;
      frame_kind_type kind;
      if ($urandom_range(0, 7) == 0) tx_quiet = !tx_quiet;
      if ($urandom_range(0, 7) == 0) rx_quiet = !rx_quiet;
      r = $urandom_range(0, 11);
      if (r == 0) begin
         n = $urandom_range(1, 3);
         repeat (n) send_byte(8'($urandom_range(0, 254)), 1'($urandom_range(0, 1)));
         stray_bytes += n;
      end else begin
         if (r == 1) begin
            // extra start byte shifts the frame by one: misaligned reply
            send_byte(START_BYTE, 1'b0);
            stray_bytes++;
         end
         kind = (r >= 8) ? FK_GOOD : frame_kind_type'($urandom_range(0, FK_RANGE_HIGH));
         send_frame(kind, pick_ppm(kind), $urandom_range(0, 5) == 0);
      end
   endtask

   initial begin
      int phase_start;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.rx_byte   <= '0;
      req_bus.avg_clear <= 1'b0;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      tx_quiet     = 1'b0;
      rx_quiet     = 1'b0;
      hold_request = 1'b0;
      frame_bytes  = 0;
      stray_bytes  = 0;
      reg_writes   = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: dropped bytes while hunting, edges of the default range,
      // average clear, broken checksum
      send_byte(8'h00, 1'b1);
      send_byte(8'hFE, 1'b0);
      stray_bytes += 2;
      send_frame(FK_GOOD, PPM_MIN_RESET, 1'b0);
      send_frame(FK_GOOD, PPM_MAX_RESET, 1'b1);
      send_frame(FK_BAD_SUM, 16'hFFFF, 1'b0);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            set_phase_regs(phase);
         end
         phase_start = frame_bytes;
         if (phase == 4) begin
            // back-to-back frames against a stalled result side
            hold_request = 1'b1;
            tx_quiet     = 1'b1;
            repeat (4) send_frame(FK_GOOD, pick_ppm(FK_GOOD), 1'b0);
            tx_quiet     = 1'b0;
         end
         while (frame_bytes - phase_start < PHASE_BYTES) random_step();
      end

      wait_drained();
      $display("Run covered %0d frame bytes, %0d stray bytes, %0d register writes;",
               frame_bytes, stray_bytes, reg_writes);
      $display("results: ok %0d, unreliable %0d, frame error %0d, not ready %0d, range %0d",
               sb.status_tally[STATUS_OK], sb.status_tally[STATUS_UNRELIABLE],
               sb.status_tally[STATUS_FRAME_ERR], sb.status_tally[STATUS_NOT_READY],
               sb.status_tally[STATUS_RANGE]);
      if (sb.error_count == 0 && sb.expected_frames.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
